@@ sv/tlq_pkg.sv @@
// Shared types and constants for the thick line quad expander.
package tlq_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  localparam logic [1:0] CFG_CAM_X = 2'd0;
  localparam logic [1:0] CFG_CAM_Y = 2'd1;
  localparam logic [1:0] CFG_CAM_Z = 2'd2;

  localparam logic signed [15:0] CAM_Z_RST = -16'sd16384;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } cam_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic [31:0]        col;
  } pt_t;

  typedef struct packed {
    logic [30:0] w;
    logic [2:0]  neg;
    logic        degen;
  } ctl_t;

  typedef struct packed {
    pt_t  pt;
    ctl_t ctl;
  } carry_t;

endpackage

@@ sv/tlq_front.sv @@
// Direction, cross product with camera vector, magnitudes and signs.
module tlq_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  tlq_pkg::carry_t        in_carry,
  input  tlq_pkg::cam_t          cam,
  output logic                   out_vld,
  output tlq_pkg::carry_t        out_carry,
  output logic [2:0][49:0]       out_mag
);

  logic                  vld1_r, vld2_r, vld3_r;
  tlq_pkg::carry_t       car1_r, car2_r, car3_r;
  logic signed [32:0]    dx_r, dy_r, dz_r;
  logic signed [48:0]    p_r [6];
  logic [2:0][49:0]      mag_r;
  logic signed [49:0]    c0, c1, c2;
  tlq_pkg::carry_t       car3_nxt;
  logic [2:0][49:0]      mag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    car1_r <= in_carry;
    dx_r   <= 33'(in_carry.pt.ex) - 33'(in_carry.pt.sx);
    dy_r   <= 33'(in_carry.pt.ey) - 33'(in_carry.pt.sy);
    dz_r   <= 33'(in_carry.pt.ez) - 33'(in_carry.pt.sz);
    car2_r <= car1_r;
    p_r[0] <= 49'(dy_r) * 49'(cam.z);
    p_r[1] <= 49'(dz_r) * 49'(cam.y);
    p_r[2] <= 49'(dz_r) * 49'(cam.x);
    p_r[3] <= 49'(dx_r) * 49'(cam.z);
    p_r[4] <= 49'(dx_r) * 49'(cam.y);
    p_r[5] <= 49'(dy_r) * 49'(cam.x);
    car3_r <= car3_nxt;
    mag_r  <= mag_nxt;
  end

  always_comb begin
    c0 = 50'(p_r[0]) - 50'(p_r[1]);
    c1 = 50'(p_r[2]) - 50'(p_r[3]);
    c2 = 50'(p_r[4]) - 50'(p_r[5]);
    mag_nxt[0] = c0[49] ? 50'(-c0) : 50'(c0);
    mag_nxt[1] = c1[49] ? 50'(-c1) : 50'(c1);
    mag_nxt[2] = c2[49] ? 50'(-c2) : 50'(c2);
    car3_nxt = car2_r;
    car3_nxt.ctl.neg   = {c2[49], c1[49], c0[49]};
    car3_nxt.ctl.degen = (c0 == '0) && (c1 == '0) && (c2 == '0);
  end

  assign out_vld   = vld3_r;
  assign out_carry = car3_r;
  assign out_mag   = mag_r;

endmodule

@@ sv/tlq_norm.sv @@
// Scales magnitudes so the largest lies in [2^30, 2^31) and sums their squares.
module tlq_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  tlq_pkg::carry_t   in_carry,
  input  logic [2:0][49:0]  in_mag,
  output logic              out_vld,
  output tlq_pkg::carry_t   out_carry,
  output logic [2:0][30:0]  out_mag,
  output logic [63:0]       out_n2
);

  logic              vld1_r, vld2_r, vld3_r, vld4_r;
  tlq_pkg::carry_t   car1_r, car2_r, car3_r, car4_r;
  logic [2:0][49:0]  mag1_r;
  logic [5:0]        msb1_r;
  logic [2:0][30:0]  sh2_r, sh3_r, sh4_r;
  logic [2:0][61:0]  sq3_r;
  logic [63:0]       n2_r;
  logic [49:0]       orv;
  logic [5:0]        msb_nxt;
  logic [2:0][30:0]  sh_nxt;
  logic [49:0]       tmp;

  always_comb begin
    orv = in_mag[0] | in_mag[1] | in_mag[2];
    msb_nxt = '0;
    for (int i = 0; i < 50; i++) begin
      if (orv[i]) msb_nxt = 6'(i);
    end
  end

  always_comb begin
    tmp = '0;
    for (int i = 0; i < 3; i++) begin
      if (msb1_r >= 6'd30) tmp = mag1_r[i] >> (msb1_r - 6'd30);
      else                 tmp = mag1_r[i] << (6'd30 - msb1_r);
      sh_nxt[i] = tmp[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    car1_r <= in_carry;
    mag1_r <= in_mag;
    msb1_r <= msb_nxt;
    car2_r <= car1_r;
    sh2_r  <= sh_nxt;
    car3_r <= car2_r;
    sh3_r  <= sh2_r;
    for (int i = 0; i < 3; i++) begin
      sq3_r[i] <= 62'(sh2_r[i]) * 62'(sh2_r[i]);
    end
    car4_r <= car3_r;
    sh4_r  <= sh3_r;
    n2_r   <= 64'(sq3_r[0]) + 64'(sq3_r[1]) + 64'(sq3_r[2]);
  end

  assign out_vld   = vld4_r;
  assign out_carry = car4_r;
  assign out_mag   = sh4_r;
  assign out_n2    = n2_r;

endmodule

@@ sv/tlq_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module tlq_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  tlq_pkg::carry_t   in_carry,
  input  logic [2:0][30:0]  in_mag,
  input  logic [63:0]       in_n2,
  output logic              out_vld,
  output tlq_pkg::carry_t   out_carry,
  output logic [2:0][30:0]  out_mag,
  output logic [31:0]       out_len
);

  localparam int NS = tlq_pkg::SQRT_STEPS;

  logic              vld_r  [NS+1];
  tlq_pkg::carry_t   car_r  [NS+1];
  logic [2:0][30:0]  mag_r  [NS+1];
  logic [63:0]       rad_r  [NS+1];
  logic [32:0]       rem_r  [NS+1];
  logic [31:0]       root_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    car_r[0]  <= in_carry;
    mag_r[0]  <= in_mag;
    rad_r[0]  <= in_n2;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [34:0] rem2, trial, diff;
    logic        ge;
    always_comb begin
      rem2  = {rem_r[k-1], rad_r[k-1][63:62]};
      trial = {1'b0, root_r[k-1], 2'b01};
      ge    = rem2 >= trial;
      diff  = rem2 - trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else        vld_r[k] <= vld_r[k-1];
    end
    always_ff @(posedge clk) begin
      car_r[k]  <= car_r[k-1];
      mag_r[k]  <= mag_r[k-1];
      rad_r[k]  <= {rad_r[k-1][61:0], 2'b00};
      rem_r[k]  <= ge ? diff[32:0] : rem2[32:0];
      root_r[k] <= {root_r[k-1][30:0], ge};
    end
  end

  assign out_vld   = vld_r[NS];
  assign out_carry = car_r[NS];
  assign out_mag   = mag_r[NS];
  assign out_len   = root_r[NS];

endmodule

@@ sv/tlq_div.sv @@
// Side magnitudes: (a*w + L) / (2L), restoring division one bit per stage.
module tlq_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  tlq_pkg::carry_t   in_carry,
  input  logic [2:0][30:0]  in_mag,
  input  logic [31:0]       in_len,
  output logic              out_vld,
  output tlq_pkg::carry_t   out_carry,
  output logic [2:0][30:0]  out_q
);

  localparam int ND = tlq_pkg::DIV_STEPS;

  logic              vld_r [ND+1];
  tlq_pkg::carry_t   car_r [ND+1];
  logic [32:0]       den_r [ND+1];
  logic [2:0][32:0]  rem_r [ND+1];
  logic [2:0][30:0]  nlo_r [ND+1];
  logic [2:0][30:0]  q_r   [ND+1];
  logic [2:0][62:0]  num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = 63'(62'(in_mag[i]) * 62'(in_carry.ctl.w)) + 63'(in_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    car_r[0] <= in_carry;
    den_r[0] <= {in_len, 1'b0};
    for (int i = 0; i < 3; i++) begin
      rem_r[0][i] <= {1'b0, num[i][62:31]};
      nlo_r[0][i] <= num[i][30:0];
    end
    q_r[0] <= '0;
  end

  for (genvar k = 1; k <= ND; k++) begin : g_step
    logic [2:0][33:0] rem2, diff;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {rem_r[k-1][i], nlo_r[k-1][i][30]};
        ge[i]   = rem2[i] >= {1'b0, den_r[k-1]};
        diff[i] = rem2[i] - {1'b0, den_r[k-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else        vld_r[k] <= vld_r[k-1];
    end
    always_ff @(posedge clk) begin
      car_r[k] <= car_r[k-1];
      den_r[k] <= den_r[k-1];
      for (int i = 0; i < 3; i++) begin
        rem_r[k][i] <= ge[i] ? diff[i][32:0] : rem2[i][32:0];
        nlo_r[k][i] <= {nlo_r[k-1][i][29:0], 1'b0};
        q_r[k][i]   <= {q_r[k-1][i][29:0], ge[i]};
      end
    end
  end

  assign out_vld   = vld_r[ND];
  assign out_carry = car_r[ND];
  assign out_q     = q_r[ND];

endmodule

@@ sv/thick_line_quad_expander_unit.sv @@
// Camera-facing thick line expander: one segment in, four strip vertices out, one per cycle.
// A request is taken when start is high and busy is low; busy is then held high by a
// down-counter that spaces requests for the four-vertex result channel. Segments still in
// arithmetic pipeline (cross product, normalize, 32-stage square root, 31-stage divide) do
// not block a new request, and the pipeline does not stall. The four vertex strobes of a
// request follow on consecutive cycles and cannot be held off. The user must write camera
// registers only while no request is in flight; the block itself does not enforce it.
module thick_line_quad_expander_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_start_z,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_end_z,
  input  logic [30:0]        in_line_width,
  input  logic [31:0]        in_line_color,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic               out_tex_u,
  output logic               out_tex_v,
  output logic [31:0]        out_vert_color,
  output logic [1:0]         out_corner,
  output logic               out_degenerate,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  tlq_pkg::cam_t     cam_r;
  logic [1:0]        hold_r;
  logic              req;
  tlq_pkg::carry_t   in_car;
  logic              f_vld, n_vld, s_vld, d_vld;
  tlq_pkg::carry_t   f_car, n_car, s_car, d_car;
  logic [2:0][49:0]  f_mag;
  logic [2:0][30:0]  n_mag, s_mag, d_q;
  logic [63:0]       n_n2;
  logic [31:0]       s_len;

  tlq_pkg::pt_t      hpt_r;
  logic [2:0][30:0]  hq_r;
  logic [2:0]        hneg_r;
  logic              hdeg_r;
  logic              act_r;
  logic [1:0]        k_r;

  logic              vout_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [31:0]       col_r;
  logic [1:0]        cor_r;
  logic              deg_r;
  logic signed [31:0] px_nxt, py_nxt, pz_nxt;

  function automatic logic signed [31:0] vtx(input logic signed [31:0] base,
                                             input logic [30:0] q, input logic neg,
                                             input logic deg, input logic plus);
    logic signed [32:0] side;
    logic signed [32:0] sum;
    side = deg ? 33'sd0 : (neg ? -$signed({2'b00, q}) : $signed({2'b00, q}));
    sum  = plus ? 33'(base) + side : 33'(base) - side;
    if (sum > 33'sd2147483647)        return 32'h7FFF_FFFF;
    else if (sum < -33'sd2147483648)  return 32'h8000_0000;
    else                              return sum[31:0];
  endfunction

  assign req       = start && !busy;
  assign busy      = (hold_r != 2'd0) || !rst_n;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.x <= '0;
      cam_r.y <= '0;
      cam_r.z <= tlq_pkg::CAM_Z_RST;
      hold_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tlq_pkg::CFG_CAM_X: cam_r.x <= cfg_data;
          tlq_pkg::CFG_CAM_Y: cam_r.y <= cfg_data;
          tlq_pkg::CFG_CAM_Z: cam_r.z <= cfg_data;
          default: ;
        endcase
      end
      if (req)                 hold_r <= 2'd3;
      else if (hold_r != 2'd0) hold_r <= hold_r - 2'd1;
    end
  end

  always_comb begin
    in_car.pt.sx     = in_start_x;
    in_car.pt.sy     = in_start_y;
    in_car.pt.sz     = in_start_z;
    in_car.pt.ex     = in_end_x;
    in_car.pt.ey     = in_end_y;
    in_car.pt.ez     = in_end_z;
    in_car.pt.col    = in_line_color;
    in_car.ctl.w     = in_line_width;
    in_car.ctl.neg   = '0;
    in_car.ctl.degen = 1'b0;
  end

  tlq_front u_front (
    .clk, .rst_n, .in_vld(req), .in_carry(in_car), .cam(cam_r),
    .out_vld(f_vld), .out_carry(f_car), .out_mag(f_mag)
  );

  tlq_norm u_norm (
    .clk, .rst_n, .in_vld(f_vld), .in_carry(f_car), .in_mag(f_mag),
    .out_vld(n_vld), .out_carry(n_car), .out_mag(n_mag), .out_n2(n_n2)
  );

  tlq_sqrt u_sqrt (
    .clk, .rst_n, .in_vld(n_vld), .in_carry(n_car), .in_mag(n_mag), .in_n2(n_n2),
    .out_vld(s_vld), .out_carry(s_car), .out_mag(s_mag), .out_len(s_len)
  );

  tlq_div u_div (
    .clk, .rst_n, .in_vld(s_vld), .in_carry(s_car), .in_mag(s_mag), .in_len(s_len),
    .out_vld(d_vld), .out_carry(d_car), .out_q(d_q)
  );

  always_comb begin
    if (k_r[1]) begin
      px_nxt = vtx(hpt_r.sx, hq_r[0], hneg_r[0], hdeg_r, k_r[0]);
      py_nxt = vtx(hpt_r.sy, hq_r[1], hneg_r[1], hdeg_r, k_r[0]);
      pz_nxt = vtx(hpt_r.sz, hq_r[2], hneg_r[2], hdeg_r, k_r[0]);
    end else begin
      px_nxt = vtx(hpt_r.ex, hq_r[0], hneg_r[0], hdeg_r, k_r[0]);
      py_nxt = vtx(hpt_r.ey, hq_r[1], hneg_r[1], hdeg_r, k_r[0]);
      pz_nxt = vtx(hpt_r.ez, hq_r[2], hneg_r[2], hdeg_r, k_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      k_r    <= '0;
      vout_r <= 1'b0;
    end else begin
      vout_r <= act_r;
      if (act_r) begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) act_r <= 1'b0;
      end
      if (d_vld) begin
        act_r <= 1'b1;
        k_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_vld) begin
      hpt_r  <= d_car.pt;
      hq_r   <= d_q;
      hneg_r <= d_car.ctl.neg;
      hdeg_r <= d_car.ctl.degen;
    end
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pz_r  <= pz_nxt;
    col_r <= hpt_r.col;
    cor_r <= k_r;
    deg_r <= hdeg_r;
  end

  assign out_valid      = vout_r;
  assign out_pos_x      = px_r;
  assign out_pos_y      = py_r;
  assign out_pos_z      = pz_r;
  assign out_tex_u      = !cor_r[1];
  assign out_tex_v      = cor_r[0];
  assign out_vert_color = col_r;
  assign out_corner     = cor_r;
  assign out_degenerate = deg_r;
  assign out_last       = (cor_r == 2'd3);

endmodule

@@ sv/tlq_checker.sv @@
// Port-level checks for the thick line quad expander, bound to the top level.
module tlq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_corner,
  input logic [31:0] out_vert_color,
  input logic        out_degenerate,
  input logic        out_last
);

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request not followed by busy");

  a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_corner != 2'd3) |=>
      out_valid && (out_corner == $past(out_corner) + 2'd1))
    else $error("vertex sequence broken");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_corner == 2'd3)))
    else $error("last flag mismatch");

  a_quad_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_corner != 2'd0) |->
      $stable(out_vert_color) && $stable(out_degenerate))
    else $error("color or degenerate changed within quad");

endmodule

bind thick_line_quad_expander_unit tlq_checker u_tlq_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_corner, .out_vert_color,
  .out_degenerate, .out_last
);

@@ dv/thick_line_quad_expander_unit_tb.sv @@
// Testbench for the thick line quad expander: directed and random segments, predicted vertices.
module thick_line_quad_expander_unit_tb;

  typedef struct {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [30:0]        w;
    logic [31:0]        col;
  } seg_t;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic               u, v;
    logic [31:0]        col;
    logic [1:0]         corner;
    logic               degen, last;
  } vert_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [15:0] data;
    seg_t        seg;
    bit          drain;
  } request_t;

  logic clk = 0, rst_n = 0;
  logic start = 0, cfg_valid = 0;
  logic busy, cfg_ready, out_valid;
  logic signed [31:0] in_start_x = 0, in_start_y = 0, in_start_z = 0;
  logic signed [31:0] in_end_x = 0, in_end_y = 0, in_end_z = 0;
  logic [30:0] in_line_width = 0;
  logic [31:0] in_line_color = 0;
  logic [1:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_tex_u, out_tex_v, out_degenerate, out_last;
  logic [31:0] out_vert_color;
  logic [1:0]  out_corner;

  thick_line_quad_expander_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  request_t       pending[$];
  vert_t          vert_q[$];
  tlq_pkg::cam_t  cam_model;
  int             gap_pct = 28;
  int             errors = 0;
  int             stall_cycles = 0;
  int             settle = 0;

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  task automatic expand_quad(seg_t s);
    logic signed [63:0] d[3], cm[3], c[3], sd[3], base;
    logic [63:0] a[3], m, len, q;
    logic [127:0] num;
    bit ng[3], dg;
    vert_t vt;
    d[0] = s.ex - s.sx; d[1] = s.ey - s.sy; d[2] = s.ez - s.sz;
    cm[0] = cam_model.x; cm[1] = cam_model.y; cm[2] = cam_model.z;
    c[0] = d[1] * cm[2] - d[2] * cm[1];
    c[1] = d[2] * cm[0] - d[0] * cm[2];
    c[2] = d[0] * cm[1] - d[1] * cm[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = c[i] < 0;
      a[i] = ng[i] ? -c[i] : c[i];
      if (a[i] > m) m = a[i];
      sd[i] = 0;
    end
    dg = (m == 0);
    if (!dg) begin
      while (m >= 64'd1 << 31) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) a[i] >>= 1;
      end
      while (m < 64'd1 << 30) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      len = isqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      for (int i = 0; i < 3; i++) begin
        num = 128'(a[i]) * 128'(s.w) + 128'(len);
        q = 64'(num / (128'(len) * 2));
        sd[i] = ng[i] ? -$signed(q) : $signed(q);
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (i == 0) base = (k < 2) ? s.ex : s.sx;
        else if (i == 1) base = (k < 2) ? s.ey : s.sy;
        else base = (k < 2) ? s.ez : s.sz;
        base = (k & 1) ? base + sd[i] : base - sd[i];
        if (i == 0) vt.px = clamp32(base);
        else if (i == 1) vt.py = clamp32(base);
        else vt.pz = clamp32(base);
      end
      vt.u = (k < 2);
      vt.v = k[0];
      vt.col = s.col;
      vt.corner = k[1:0];
      vt.degen = dg;
      vt.last = (k == 3);
      vert_q.push_back(vt);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      cfg_valid <= 0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 0;
      case (cfg_index)
        tlq_pkg::CFG_CAM_X: cam_model.x <= cfg_data;
        tlq_pkg::CFG_CAM_Y: cam_model.y <= cfg_data;
        tlq_pkg::CFG_CAM_Z: cam_model.z <= cfg_data;
        default: ;
      endcase
      settle <= 0;
    end else if (cfg_valid) begin
    end else begin
      if (start && !busy) expand_quad(pending[0].seg);
      if (start && !busy) void'(pending.pop_front());
      if (start && busy) begin
      end else if (pending.size() == 0) begin
        start <= 0;
      end else if (pending[0].is_cfg || pending[0].drain) begin
        start <= 0;
        if (vert_q.size() != 0 || (start && !busy)) settle <= 0;
        else if (settle < 100) settle <= settle + 1;
        else if (pending[0].drain) begin
          void'(pending.pop_front());
          settle <= 0;
        end else begin
          cfg_valid <= 1;
          cfg_index <= pending[0].idx;
          cfg_data <= pending[0].data;
          void'(pending.pop_front());
        end
      end else if ($urandom_range(99) < gap_pct) begin
        start <= 0;
      end else begin
        start <= 1;
        in_start_x <= pending[0].seg.sx;
        in_start_y <= pending[0].seg.sy;
        in_start_z <= pending[0].seg.sz;
        in_end_x <= pending[0].seg.ex;
        in_end_y <= pending[0].seg.ey;
        in_end_z <= pending[0].seg.ez;
        in_line_width <= pending[0].seg.w;
        in_line_color <= pending[0].seg.col;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vert_t e;
    if (rst_n && out_valid) begin
      if (vert_q.size() == 0) begin
        $display("%0t unexpected vertex pos=%h %h %h", $time, out_pos_x, out_pos_y, out_pos_z);
        errors++;
      end else begin
        e = vert_q.pop_front();
        if ({out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v, out_vert_color,
             out_corner, out_degenerate, out_last} !==
            {e.px, e.py, e.pz, e.u, e.v, e.col, e.corner, e.degen, e.last}) begin
          $display("%0t mismatch exp pos=%h %h %h u=%b v=%b col=%h c=%0d dg=%b l=%b",
                   $time, e.px, e.py, e.pz, e.u, e.v, e.col, e.corner, e.degen, e.last);
          $display("%0t          act pos=%h %h %h u=%b v=%b col=%h c=%0d dg=%b l=%b",
                   $time, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
                   out_vert_color, out_corner, out_degenerate, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 4000)) - 2000;
      2: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(100)
                                  : 32'sh80000000 + $urandom_range(100);
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  task automatic add_seg(logic signed [31:0] sx, sy, sz, ex, ey, ez,
                         logic [30:0] w, logic [31:0] col);
    request_t r;
    r = '{default: 0};
    r.seg = '{sx, sy, sz, ex, ey, ez, w, col};
    pending.push_back(r);
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [15:0] data);
    request_t r;
    r = '{default: 0};
    r.is_cfg = 1;
    r.idx = idx;
    r.data = data;
    pending.push_back(r);
  endtask

  task automatic add_random(int n);
    int md;
    logic signed [31:0] sx, sy, sz;
    for (int i = 0; i < n; i++) begin
      md = $urandom_range(3);
      sx = rand_coord(md); sy = rand_coord(md); sz = rand_coord(md);
      if ($urandom_range(9) == 0) add_seg(sx, sy, sz, sx, sy, sz, 31'($urandom), $urandom);
      else add_seg(sx, sy, sz, rand_coord(md), rand_coord(md), rand_coord(md),
                   $urandom_range(3) == 0 ? 31'(~$urandom_range(3)) : 31'($urandom),
                   $urandom);
    end
  endtask

  task automatic set_cam(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    add_cfg(tlq_pkg::CFG_CAM_X, x);
    add_cfg(tlq_pkg::CFG_CAM_Y, y);
    add_cfg(tlq_pkg::CFG_CAM_Z, z);
  endtask

  initial begin
    request_t r;
    cam_model.x = 0;
    cam_model.y = 0;
    cam_model.z = tlq_pkg::CAM_Z_RST;
    // directed, reset camera
    add_seg(0, 0, 0, 32'sh10000, 0, 0, 31'h20000, 32'hdeadbeef);
    add_seg(5, 5, 5, 5, 5, 5, 31'h7fffffff, 32'hffffffff);
    add_seg(0, 0, 0, 0, 0, 32'sh40000, 31'h10000, 0);
    add_seg(32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, 0,
            31'h7fffffff, 32'h12345678);
    add_seg(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 31'h7fffffff, 32'h1);
    add_seg(32'sh7ffffff0, 32'sh7ffffff0, 0, 32'sh7ffffff0, 32'sh7ffffff8, 0,
            31'h7fffffff, 32'h80000000);
    add_seg(0, 0, 0, 1, 0, 0, 31'h0, 32'h55aa55aa);
    add_seg(0, 0, 0, 1, 1, 0, 31'h1, 32'haa55aa55);
    set_cam(16'sd16384, 16'sd0, 16'sd0);
    add_seg(0, 0, 0, 32'sh10000, 0, 0, 31'h20000, 32'h1);
    add_seg(0, 0, 0, 0, 32'sh10000, 32'sh10000, 31'h30000, 32'h2);
    set_cam(16'sd0, 16'sd0, 16'sd0);
    add_seg(0, 0, 0, 32'sh10000, 32'sh20000, 32'sh30000, 31'h20000, 32'h3);
    set_cam(-16'sd16384, -16'sd16384, 16'sd16384);
    add_seg(1, 2, 3, -32'sd70000, 90000, 12, 31'h7fffffff, 32'h4);
    add_seg(0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 32'h5);
    set_cam(16'sd11585, 16'sd0, -16'sd11585);
    add_random(110);
    r = '{default: 0};
    r.drain = 1;
    pending.push_back(r);
    add_random(10);
    set_cam(16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
            16'($urandom_range(32768) - 16384));
    add_random(115);
    set_cam(16'sd9459, -16'sd9459, 16'sd9459);
    add_random(110);
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    while (pending.size() > 230) @(posedge clk);
    gap_pct = 75;
    while (pending.size() > 115) @(posedge clk);
    gap_pct = 0;
    while (pending.size() != 0 || start) @(posedge clk);
    while (vert_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && vert_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
